/* rtl/core/qta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quota accounter package
// Widths, request and status codes, and record types shared by the quota
// accounter modules.
// ----------------------------------------------------------------------------
package qta_pkg;

  localparam int MOUNT_SLOTS = 16;
  localparam int TYPE_W      = 3;
  localparam int ID_W        = 4;
  localparam int BYTES_W     = 48;
  localparam int INODE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int ID_RANGE    = 1 << ID_W;
  localparam int SLOT_W      = (MOUNT_SLOTS > 1) ? $clog2(MOUNT_SLOTS) : 1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_RSV_BYTES  = 3'd0,
    REQ_REL_BYTES  = 3'd1,
    REQ_RSV_INODE  = 3'd2,
    REQ_REL_INODE  = 3'd3,
    REQ_SET_LIMITS = 3'd4
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOSPACE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef logic [SLOT_W-1:0] slot_t;

  // One request as held in the input stage
  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [ID_W-1:0]    mount_id;
    logic [BYTES_W-1:0] amount;
    logic [INODE_W-1:0] inode_limit;
  } req_t;

  // Per-slot accounting record
  typedef struct packed {
    logic [BYTES_W-1:0] used;
    logic [INODE_W-1:0] inodes;
    logic [BYTES_W-1:0] byte_cap;
    logic [INODE_W-1:0] inode_lim;
  } slot_rec_t;

  // Write of one slot record and the global counter
  typedef struct packed {
    logic               en;
    slot_t              slot;
    slot_rec_t          rec;
    logic [BYTES_W-1:0] total_used;
  } upd_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTES_W-1:0]  global_used_now;
    logic [BYTES_W-1:0]  mount_used_now;
    logic [INODE_W-1:0]  inode_count_now;
  } rsp_t;

  // Mount id to slot, folded when there are fewer slots than ids
  typedef slot_t slot_map_t [ID_RANGE];

  function automatic slot_map_t build_slot_map();
    slot_map_t m;
    for (int i = 0; i < ID_RANGE; i++) begin
      m[i] = slot_t'(i % MOUNT_SLOTS);
    end
    return m;
  endfunction

  localparam slot_map_t SLOT_MAP = build_slot_map();

endpackage
`default_nettype wire

/* rtl/core/qta_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quota request channel
// Valid/ready channel that carries one accounting request per transfer.
// ----------------------------------------------------------------------------
interface qta_req_if
  import qta_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [ID_W-1:0]    mount_id;
  logic [BYTES_W-1:0] amount;
  logic [INODE_W-1:0] inode_limit;

  modport source (output valid, req_type, mount_id, amount, inode_limit, input ready);
  modport sink   (input valid, req_type, mount_id, amount, inode_limit, output ready);
endinterface
`default_nettype wire

/* rtl/core/qta_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quota response channel
// Valid/ready channel that carries one accounting result per transfer.
// ----------------------------------------------------------------------------
interface qta_rsp_if
  import qta_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTES_W-1:0]  global_used_now;
  logic [BYTES_W-1:0]  mount_used_now;
  logic [INODE_W-1:0]  inode_count_now;

  modport source (output valid, status, global_used_now, mount_used_now,
                  inode_count_now, input ready);
  modport sink   (input valid, status, global_used_now, mount_used_now,
                  inode_count_now, output ready);
endinterface
`default_nettype wire

/* rtl/core/qta_slot_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quota slot store
// Per-mount counters and caps plus the global byte counter, read at one
// slot and written back once per processed request.
// ----------------------------------------------------------------------------
module qta_slot_store
  import qta_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire slot_t              rd_slot,
  output      slot_rec_t          rd_rec,
  output      logic [BYTES_W-1:0] rd_global,
  input  wire upd_t               upd
);

  slot_rec_t          slots [MOUNT_SLOTS];
  logic [BYTES_W-1:0] total_used;

  // Read the addressed slot
  assign rd_rec    = slots[rd_slot];
  assign rd_global = total_used;

  // Clear on reset, write back the updated record
  always_ff @(posedge clk) begin
    if (rst) begin
      total_used <= '0;
      for (int i = 0; i < MOUNT_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (upd.en) begin
      total_used       <= upd.total_used;
      slots[upd.slot]  <= upd.rec;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/qta_calc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quota update logic
// Checks a request against the global and mount caps and forms the new
// slot record, global counter and result.
// ----------------------------------------------------------------------------
module qta_calc
  import qta_pkg::*;
(
  input  wire req_t               req,
  input  wire slot_rec_t          cur_rec,
  input  wire logic [BYTES_W-1:0] cur_global,
  input  wire logic [BYTES_W-1:0] cap_limit,
  output      slot_rec_t          next_rec,
  output      logic [BYTES_W-1:0] next_global,
  output      rsp_t               result
);

  logic    amt_zero;
  logic    g_fit;
  logic    m_fit;
  status_t status;

  // Room checks: usage must sit at or under the cap and the amount fit the rest
  assign amt_zero = (req.amount == '0);
  assign g_fit    = (cur_global <= cap_limit) &&
                    (req.amount <= cap_limit - cur_global);
  assign m_fit    = (cur_rec.used <= cur_rec.byte_cap) &&
                    (req.amount <= cur_rec.byte_cap - cur_rec.used);

  // Apply the request
  always_comb begin
    next_rec    = cur_rec;
    next_global = cur_global;
    status      = ST_OK;
    case (req_type_t'(req.req_type))
      REQ_RSV_BYTES: begin
        if (!amt_zero) begin
          if (g_fit && m_fit) begin
            next_global  = cur_global + req.amount;
            next_rec.used = cur_rec.used + req.amount;
          end else begin
            status = ST_NOSPACE;
          end
        end
      end
      REQ_REL_BYTES: begin
        if (!amt_zero) begin
          if (req.amount > cur_rec.used) begin
            next_rec.used = '0;
            status        = ST_UNDERFLOW;
          end else begin
            next_rec.used = cur_rec.used - req.amount;
          end
          if (req.amount > cur_global) begin
            next_global = '0;
            status      = ST_UNDERFLOW;
          end else begin
            next_global = cur_global - req.amount;
          end
        end
      end
      REQ_RSV_INODE: begin
        if (cur_rec.inodes >= cur_rec.inode_lim) begin
          status = ST_NOSPACE;
        end else begin
          next_rec.inodes = cur_rec.inodes + INODE_W'(1);
        end
      end
      REQ_REL_INODE: begin
        if (cur_rec.inodes == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          next_rec.inodes = cur_rec.inodes - INODE_W'(1);
        end
      end
      REQ_SET_LIMITS: begin
        next_rec.byte_cap  = req.amount;
        next_rec.inode_lim = req.inode_limit;
      end
      default: begin
        next_rec = cur_rec;
      end
    endcase
  end

  // Report the values after the update
  assign result.status          = status;
  assign result.global_used_now = next_global;
  assign result.mount_used_now  = next_rec.used;
  assign result.inode_count_now = next_rec.inodes;

endmodule
`default_nettype wire

/* rtl/core/two_level_quota_accounter.sv */
`timescale 1ns / 1ps
`default_nettype none
// A transferred request is held in the input register, and its result is then
// captured in the result register, from which the response transfers.
// Throughput: one request per cycle unless the response side stalls; slot read,
// cap check and write-back close together, so back-to-back requests chain.
// Reset (rst, synchronous) clears the global cap register, the global counter
// and every slot's counters and caps, and empties both pipeline registers.
// ----------------------------------------------------------------------------
// Two-level quota accounter
// Global and per-mount byte quota with per-mount inode quota: an input
// register, the update logic over the slot store, and a result register.
// ----------------------------------------------------------------------------
module two_level_quota_accounter
  import qta_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [BYTES_W-1:0] cfg_wdata,
  qta_req_if.sink                 req,
  qta_rsp_if.source               rsp
);

  logic               cap_we;
  logic [BYTES_W-1:0] cap_limit;
  logic               s1_valid;
  req_t               s1_req;
  logic               s1_adv;
  logic               fire;
  slot_t              s1_slot;
  slot_rec_t          cur_rec;
  logic [BYTES_W-1:0] cur_global;
  slot_rec_t          next_rec;
  logic [BYTES_W-1:0] next_global;
  rsp_t               result;
  upd_t               upd;
  logic               out_valid;
  rsp_t               out_data;

  // Hold the global cap register
  assign cap_we = cfg_we;
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= '0;
    end else if (cap_we) begin
      cap_limit <= cfg_wdata;
    end
  end

  // Stage handshakes: the input stage advances when the result register frees
  assign s1_adv    = !out_valid || rsp.ready;
  assign fire      = s1_valid && s1_adv;
  assign req.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req.req_type    <= req.req_type;
      s1_req.mount_id    <= req.mount_id;
      s1_req.amount      <= req.amount;
      s1_req.inode_limit <= req.inode_limit;
    end
  end

  assign s1_slot = SLOT_MAP[s1_req.mount_id];

  qta_slot_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_slot   (s1_slot),
    .rd_rec    (cur_rec),
    .rd_global (cur_global),
    .upd       (upd)
  );

  qta_calc u_calc (
    .req         (s1_req),
    .cur_rec     (cur_rec),
    .cur_global  (cur_global),
    .cap_limit   (cap_limit),
    .next_rec    (next_rec),
    .next_global (next_global),
    .result      (result)
  );

  // Write back when the request leaves the input stage
  assign upd.en          = fire;
  assign upd.slot        = s1_slot;
  assign upd.rec         = next_rec;
  assign upd.total_used  = next_global;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_data.status;
  assign rsp.global_used_now = out_data.global_used_now;
  assign rsp.mount_used_now  = out_data.mount_used_now;
  assign rsp.inode_count_now = out_data.inode_count_now;

`ifndef SYNTHESIS
  // No result right after reset
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled request in the input stage is neither lost nor changed
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_req))
    else $error("input stage dropped or changed a stalled request");

  // The global counter only falls on a byte release
  a_global_drop: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (cur_global < $past(cur_global)) |->
      $past(fire) && ($past(s1_req.req_type) == REQ_REL_BYTES))
    else $error("global usage fell without a byte release");
`endif

endmodule
`default_nettype wire

/* dv/qta_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quota accounter checker
// Watches the request, response and global cap ports, keeps its own copy of
// the global and per-mount quota state, and compares every response with the
// result predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module qta_checker
  import qta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [BYTES_W-1:0] cfg_wdata,
  qta_req_if                 req,
  qta_rsp_if                 rsp,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  logic [BYTES_W-1:0] cap_total;
  logic [BYTES_W-1:0] used_total;
  logic [BYTES_W-1:0] slot_used   [MOUNT_SLOTS];
  logic [INODE_W-1:0] slot_inodes [MOUNT_SLOTS];
  logic [BYTES_W-1:0] slot_bcap   [MOUNT_SLOTS];
  logic [INODE_W-1:0] slot_icap   [MOUNT_SLOTS];

  rsp_t owed_rsp[$];
  int   n_errors  = 0;
  int   n_checked = 0;

  // True when delta more bytes fit under cap at the given usage
  function automatic logic has_room(input logic [BYTES_W-1:0] used, cap, delta);
    if (used > cap) return 1'b0;
    return delta <= cap - used;
  endfunction

  // Apply one request to the quota state and return the result it produces
  function automatic rsp_t apply_request(input logic [TYPE_W-1:0]  kind,
                                         input logic [ID_W-1:0]    id,
                                         input logic [BYTES_W-1:0] amt,
                                         input logic [INODE_W-1:0] ilim);
    int   s;
    logic clipped;
    rsp_t r;
    s        = int'(id) % MOUNT_SLOTS;
    clipped  = 1'b0;
    r.status = ST_OK;
    case (kind)
      REQ_RSV_BYTES: begin
        if (amt != '0) begin
          if (has_room(used_total, cap_total, amt) &&
              has_room(slot_used[s], slot_bcap[s], amt)) begin
            used_total   = used_total + amt;
            slot_used[s] = slot_used[s] + amt;
          end else begin
            r.status = ST_NOSPACE;
          end
        end
      end
      REQ_REL_BYTES: begin
        // saturate each counter at zero on its own
        if (amt != '0) begin
          if (amt > slot_used[s]) begin
            slot_used[s] = '0;
            clipped      = 1'b1;
          end else begin
            slot_used[s] = slot_used[s] - amt;
          end
          if (amt > used_total) begin
            used_total = '0;
            clipped    = 1'b1;
          end else begin
            used_total = used_total - amt;
          end
          if (clipped) r.status = ST_UNDERFLOW;
        end
      end
      REQ_RSV_INODE: begin
        if (slot_inodes[s] >= slot_icap[s]) r.status = ST_NOSPACE;
        else slot_inodes[s] = slot_inodes[s] + 1'b1;
      end
      REQ_REL_INODE: begin
        if (slot_inodes[s] == '0) r.status = ST_UNDERFLOW;
        else slot_inodes[s] = slot_inodes[s] - 1'b1;
      end
      REQ_SET_LIMITS: begin
        slot_bcap[s] = amt;
        slot_icap[s] = ilim;
      end
      default: ;
    endcase
    r.global_used_now = used_total;
    r.mount_used_now  = slot_used[s];
    r.inode_count_now = slot_inodes[s];
    return r;
  endfunction

  // Track config writes, queue predictions, retire responses
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst) begin
      cap_total  = '0;
      used_total = '0;
      for (int i = 0; i < MOUNT_SLOTS; i++) begin
        slot_used[i]   = '0;
        slot_inodes[i] = '0;
        slot_bcap[i]   = '0;
        slot_icap[i]   = '0;
      end
      owed_rsp.delete();
    end else begin
      if (cfg_we) cap_total = cfg_wdata;
      if (rsp.valid && rsp.ready) begin
        got.status          = rsp.status;
        got.global_used_now = rsp.global_used_now;
        got.mount_used_now  = rsp.mount_used_now;
        got.inode_count_now = rsp.inode_count_now;
        if (owed_rsp.size() == 0) begin
          $error("response transfer with no request outstanding (status %0d)", got.status);
          n_errors++;
        end else begin
          want = owed_rsp.pop_front();
          n_checked++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_errors++;
          end
          if (got.global_used_now !== want.global_used_now) begin
            $error("global_used_now: expected %0d, got %0d",
                   want.global_used_now, got.global_used_now);
            n_errors++;
          end
          if (got.mount_used_now !== want.mount_used_now) begin
            $error("mount_used_now: expected %0d, got %0d",
                   want.mount_used_now, got.mount_used_now);
            n_errors++;
          end
          if (got.inode_count_now !== want.inode_count_now) begin
            $error("inode_count_now: expected %0d, got %0d",
                   want.inode_count_now, got.inode_count_now);
            n_errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        owed_rsp.push_back(apply_request(req.req_type, req.mount_id,
                                         req.amount, req.inode_limit));
      end
    end
    fail_count <= n_errors;
    pending    <= owed_rsp.size();
    checked    <= n_checked;
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quota accounter testbench
// Drives directed corner requests and then phases of random requests under
// several global caps, with random idle on the request side and random stall
// on the response side; the checker module predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import qta_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASES       = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // request codes the block does not define
  localparam logic [TYPE_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_LAST  = 3'd7;

  localparam logic [BYTES_W-1:0] BYTES_MAX  = '1;
  localparam logic [INODE_W-1:0] INODES_MAX = '1;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [BYTES_W-1:0] cfg_wdata;

  int   fail_count;
  int   pending;
  int   checked;
  int   sent       = 0;
  int   cycle_cnt  = 0;
  logic src_idles  = 1'b0;
  logic sink_idles = 1'b0;
  int   amt_bits   = 48;
  int   slot_span  = MOUNT_SLOTS;

  qta_req_if req_ch ();
  qta_rsp_if rsp_ch ();

  two_level_quota_accounter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  qta_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without draining", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly no gap, often a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [BYTES_W-1:0] rand_bytes(input int bits);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (bits < BYTES_W) w = w & ((64'd1 << bits) - 64'd1);
    return w[BYTES_W-1:0];
  endfunction

  // Response side: ready in random runs, stalled in random gaps
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (sink_idles) begin
        gap = pick_gap();
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Present one request and hold it until the transfer
  task automatic send(input logic [TYPE_W-1:0]  kind,
                      input logic [ID_W-1:0]    id,
                      input logic [BYTES_W-1:0] amt,
                      input logic [INODE_W-1:0] ilim);
    int gap;
    if (src_idles) begin
      gap = pick_gap();
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.mount_id    <= id;
    req_ch.amount      <= amt;
    req_ch.inode_limit <= ilim;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Hold off until every outstanding result has been returned
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_global_cap(input logic [BYTES_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random();
    int                 r;
    logic [TYPE_W-1:0]  kind;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] amt;
    logic [INODE_W-1:0] ilim;
    r = $urandom_range(0, 99);
    if (r < 36)      kind = REQ_RSV_BYTES;
    else if (r < 60) kind = REQ_REL_BYTES;
    else if (r < 74) kind = REQ_RSV_INODE;
    else if (r < 84) kind = REQ_REL_INODE;
    else if (r < 95) kind = REQ_SET_LIMITS;
    else             kind = $urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST);
    id = $urandom_range(0, slot_span - 1);
    // caps drawn a few bits wider than usage steps so reserves often fit
    r = $urandom_range(0, 99);
    if (r < 3)                        amt = '0;
    else if (r < 6)                   amt = BYTES_MAX;
    else if (kind == REQ_SET_LIMITS)  amt = rand_bytes(amt_bits + 3);
    else                              amt = rand_bytes(amt_bits);
    r = $urandom_range(0, 99);
    if (r < 70)      ilim = $urandom_range(0, 6);
    else if (r < 80) ilim = INODES_MAX;
    else             ilim = $urandom;
    send(kind, id, amt, ilim);
  endtask

  // Reset, directed corners, random phases, verdict
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_RSV_BYTES;
    req_ch.mount_id    <= '0;
    req_ch.amount      <= '0;
    req_ch.inode_limit <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // all caps zero after reset
    send(REQ_RSV_BYTES, 0, '0, '0);
    send(REQ_RSV_BYTES, 0, 48'd1, INODES_MAX);
    send(REQ_REL_BYTES, 0, 48'd5, '0);
    send(REQ_REL_INODE, 3, BYTES_MAX, '0);
    send(REQ_RSV_INODE, 3, '0, '0);
    for (int t = REQ_UNUSED_FIRST; t <= REQ_UNUSED_LAST; t++) begin
      send(TYPE_W'(t), 9, BYTES_MAX, INODES_MAX);
    end
    drain();
    set_global_cap(BYTES_MAX);

    // fill to the top, then lower the mount caps under current usage
    send(REQ_SET_LIMITS, 15, BYTES_MAX, INODES_MAX);
    send(REQ_RSV_BYTES, 15, BYTES_MAX, '0);
    send(REQ_RSV_BYTES, 15, 48'd1, '0);
    send(REQ_REL_BYTES, 15, '0, '0);
    send(REQ_SET_LIMITS, 15, 48'd5, 32'd2);
    send(REQ_RSV_BYTES, 15, 48'd1, '0);
    repeat (3) send(REQ_RSV_INODE, 15, 48'h5555_5555_5555, '0);
    send(REQ_REL_INODE, 15, '0, '0);
    // mount clips at zero while the global counter subtracts
    send(REQ_SET_LIMITS, 1, 48'd100, '0);
    send(REQ_REL_BYTES, 1, 48'd10, '0);
    send(REQ_RSV_BYTES, 1, 48'd10, '0);
    send(REQ_REL_BYTES, 15, BYTES_MAX, '0);
    send(REQ_REL_BYTES, 1, 48'd11, '0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin set_global_cap(BYTES_MAX);      amt_bits = 48; slot_span = 16; end
        1: begin set_global_cap(rand_bytes(14)); amt_bits = 10; slot_span = 4;  end
        2: begin set_global_cap('0);             amt_bits = 8;  slot_span = 16; end
        3: begin set_global_cap(rand_bytes(48)); amt_bits = 46; slot_span = 16; end
        4: begin set_global_cap(48'd1);          amt_bits = 2;  slot_span = 3;  end
        5: begin set_global_cap(rand_bytes(16)); amt_bits = 12; slot_span = 16; end
        6: begin set_global_cap(BYTES_MAX);      amt_bits = 20; slot_span = 2;  end
        default: begin
          set_global_cap(rand_bytes(24));
          amt_bits  = 18;
          slot_span = 16;
        end
      endcase
      src_idles  = (p % 4 != 0);
      sink_idles = (p % 4 == 1) || (p % 4 == 2);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        send_random();
        // occasionally let the pipe run dry mid-phase
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    $display("Checked %0d results for %0d requests across %0d global cap settings",
             checked, sent, PHASES + 2);
    $display("Covered byte and inode reserve/release, limit updates, unused codes, stalls");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
